/* design/handheld_memory_map_with_mbc1_macros.svh */
// Assertion macros for the handheld memory map block.
// Used by the top level; needs clk and rst_n in the using scope.
`ifndef HANDHELD_MEMORY_MAP_WITH_MBC1_MACROS_SVH
`define HANDHELD_MEMORY_MAP_WITH_MBC1_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define HMM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define HMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HMM_ASSERT_IMPLY(lbl, ante, cons, msg)
`define HMM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/hmm_pkg.sv */
// Shared types, codes and constants of the handheld memory map block.
// No dependencies.
package hmm_pkg;

    localparam int RAM_BANK_COUNT_DEF = 4;
    localparam int ROM_BANK_BITS_DEF  = 7;
    localparam int PADDR_W            = 3;
    localparam int INT_AW             = 15;

    // bus item codes
    localparam logic [2:0] FUNC_READ  = 3'd0;
    localparam logic [2:0] FUNC_WRITE = 3'd1;
    localparam logic [2:0] FUNC_BTN   = 3'd2;
    localparam logic [2:0] FUNC_DIV   = 3'd3;
    localparam logic [2:0] FUNC_LY    = 3'd4;

    // IO register addresses
    localparam logic [15:0] A_JOYP = 16'hFF00;
    localparam logic [15:0] A_SB   = 16'hFF01;
    localparam logic [15:0] A_SC   = 16'hFF02;
    localparam logic [15:0] A_DIV  = 16'hFF04;
    localparam logic [15:0] A_TIMA = 16'hFF05;
    localparam logic [15:0] A_LY   = 16'hFF44;
    localparam logic [15:0] A_DMA  = 16'hFF46;
    localparam logic [7:0]  SC_PRINT = 8'h81;

    // classified command kinds
    typedef enum logic [4:0] {
        K_NONE, K_ROM_RD, K_INT_RD, K_EXT_RD, K_JOYP_RD, K_SB_RD, K_DIV_RD,
        K_LY_RD, K_MBC_WR, K_EXT_WR, K_INT_WR, K_JOYP_WR, K_SB_WR, K_DIV_CLR,
        K_LY_CLR, K_BUTTON, K_DIV_TICK, K_LY_TICK
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [INT_AW-1:0]  idx;
        logic [15:0]        addr;
        logic [7:0]         data;
        logic [2:0]         button_index;
        logic               button_pressed;
        logic               sv;
        logic               tw;
        logic               dr;
    } cmd_t;

    // post-boot contents of internal store, by store index
    function automatic logic [7:0] boot_byte(input logic [INT_AW-1:0] idx);
        logic [7:0] v;
        case (idx)
            15'h7F10: v = 8'h80;
            15'h7F11: v = 8'hBF;
            15'h7F12: v = 8'hF3;
            15'h7F14: v = 8'hBF;
            15'h7F16: v = 8'h3F;
            15'h7F19: v = 8'hBF;
            15'h7F1A: v = 8'h7F;
            15'h7F1B: v = 8'hFF;
            15'h7F1C: v = 8'h9F;
            15'h7F1E: v = 8'hBF;
            15'h7F20: v = 8'hFF;
            15'h7F23: v = 8'hBF;
            15'h7F24: v = 8'h77;
            15'h7F25: v = 8'hF3;
            15'h7F26: v = 8'hF1;
            15'h7F40: v = 8'h91;
            15'h7F47: v = 8'hFC;
            15'h7F48: v = 8'hFF;
            15'h7F49: v = 8'hFF;
            default:  v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

/* design/handheld_memory_map_with_mbc1.sv */
// Top level of the handheld memory map with MBC1 mapper: config port,
// front classifier, back executor. Depends on hmm_pkg, hmm_front, hmm_back.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  input   | push / full         | func addr data button_index button_pressed
//  result  | empty / pop         | read_data rom_read rom_addr serial_valid
//          |                     | serial_byte dma_request dma_page timer_written
//  config  | psel penable pwrite | paddr pwdata prdata (pready tied high)
//
// Reads of internal RAM and of enabled external RAM pass through the S_WAIT
// state (registered RAM port); every other item loads the result slot directly.
// A two-entry queue sits between the front and the back, and one result slot
// drives the output. After reset a clearing pass loads the internal store;
// full stays high during it. Config writes are taken at any time.
`include "handheld_memory_map_with_mbc1_macros.svh"
module handheld_memory_map_with_mbc1 #(
    parameter int RAM_BANK_COUNT = hmm_pkg::RAM_BANK_COUNT_DEF,
    parameter int ROM_BANK_BITS  = hmm_pkg::ROM_BANK_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hmm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  logic [2:0]                   func,
    input  logic [15:0]                  addr,
    input  logic [7:0]                   data,
    input  logic [2:0]                   button_index,
    input  logic                         button_pressed,
    output logic                         empty,
    input  logic                         pop,
    output logic [7:0]                   read_data,
    output logic                         rom_read,
    output logic [20:0]                  rom_addr,
    output logic                         serial_valid,
    output logic [7:0]                   serial_byte,
    output logic                         dma_request,
    output logic [7:0]                   dma_page,
    output logic                         timer_written
);
    import hmm_pkg::*;

    logic  mbc1_enable_reg;
    logic  cfg_wr;
    logic  cmd_valid, cmd_take, clearing;
    cmd_t  cmd;

    // config register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == '0);
    assign prdata = (paddr == '0) ? {31'd0, mbc1_enable_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)      mbc1_enable_reg <= 1'b1;
        else if (cfg_wr) mbc1_enable_reg <= pwdata[0];
    end

    hmm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .hold           (clearing),
        .full           (full),
        .func           (func),
        .addr           (addr),
        .data           (data),
        .button_index   (button_index),
        .button_pressed (button_pressed),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_take       (cmd_take)
    );

    hmm_back #(
        .RAM_BANK_COUNT (RAM_BANK_COUNT),
        .ROM_BANK_BITS  (ROM_BANK_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .mbc1_enable    (mbc1_enable_reg),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_take       (cmd_take),
        .clearing       (clearing),
        .empty          (empty),
        .pop            (pop),
        .read_data      (read_data),
        .rom_read       (rom_read),
        .rom_addr       (rom_addr),
        .serial_valid   (serial_valid),
        .serial_byte    (serial_byte),
        .dma_request    (dma_request),
        .dma_page       (dma_page),
        .timer_written  (timer_written)
    );

    `HMM_ASSERT_IMPLY(a_clear_blocks, clearing, full, "input open during clearing pass")
    `HMM_ASSERT_IMPLY(a_rom_no_data, !empty && rom_read, read_data == 8'h00, "ROM read carries data")
    `HMM_ASSERT_IMPLY(a_dma_page, !empty && !dma_request, dma_page == 8'h00, "stray DMA page")
    `HMM_ASSERT_NEXT(a_cfg_write, cfg_wr, mbc1_enable_reg == $past(pwdata[0]), "config write lost")

endmodule

/* design/hmm_front.sv */
// Front end: accepts bus items, classifies them by address, and queues them.
// Depends on hmm_pkg.
module hmm_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             hold,
    output logic             full,
    input  logic [2:0]       func,
    input  logic [15:0]      addr,
    input  logic [7:0]       data,
    input  logic [2:0]       button_index,
    input  logic             button_pressed,
    output logic             cmd_valid,
    output hmm_pkg::cmd_t    cmd,
    input  logic             cmd_take
);
    import hmm_pkg::*;

    cmd_t        q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    cmd_t        dec;
    logic        in_beat;
    logic        ext_area, echo_area, dead_area;
    logic [15:0] echo_addr;

    // address classes
    assign ext_area  = (addr >= 16'hA000) && (addr < 16'hC000);
    assign echo_area = (addr >= 16'hE000) && (addr < 16'hFE00);
    assign dead_area = (addr >= 16'hFEA0) && (addr < 16'hFF00);
    assign echo_addr = addr - 16'h2000;

    // decode one item
    always_comb
    begin
        dec                = '0;
        dec.kind           = K_NONE;
        dec.idx            = addr[INT_AW-1:0];
        dec.addr           = addr;
        dec.data           = data;
        dec.button_index   = button_index;
        dec.button_pressed = button_pressed;
        case (func)
            FUNC_READ:
            begin
                if (addr < 16'h8000)       dec.kind = K_ROM_RD;
                else if (ext_area)         dec.kind = K_EXT_RD;
                else if (addr == A_JOYP)   dec.kind = K_JOYP_RD;
                else if (addr == A_SB)     dec.kind = K_SB_RD;
                else if (addr == A_DIV)    dec.kind = K_DIV_RD;
                else if (addr == A_LY)     dec.kind = K_LY_RD;
                else
                begin
                    dec.kind = K_INT_RD;
                    if (echo_area) dec.idx = echo_addr[INT_AW-1:0];
                end
            end
            FUNC_WRITE:
            begin
                if (addr == A_SC && data == SC_PRINT) dec.sv = 1'b1;
                else if (addr < 16'h8000)  dec.kind = K_MBC_WR;
                else if (ext_area)         dec.kind = K_EXT_WR;
                else if (echo_area)
                begin
                    dec.kind = K_INT_WR;
                    dec.idx  = echo_addr[INT_AW-1:0];
                end
                else if (dead_area)        dec.kind = K_NONE;
                else if (addr == A_DIV)    dec.kind = K_DIV_CLR;
                else if (addr == A_LY)     dec.kind = K_LY_CLR;
                else if (addr == A_TIMA)
                begin
                    dec.kind = K_INT_WR;
                    dec.tw   = 1'b1;
                end
                else if (addr == A_DMA)    dec.dr = 1'b1;
                else if (addr == A_JOYP)   dec.kind = K_JOYP_WR;
                else if (addr == A_SB)     dec.kind = K_SB_WR;
                else                       dec.kind = K_INT_WR;
            end
            FUNC_BTN: dec.kind = K_BUTTON;
            FUNC_DIV: dec.kind = K_DIV_TICK;
            FUNC_LY:  dec.kind = K_LY_TICK;
            default:  dec.kind = K_NONE;
        endcase
    end

    // two-entry queue toward the back end
    assign full      = (cnt_reg == 2'd2) || hold;
    assign in_beat   = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ in_beat;
        rd_ptr_next = rd_ptr_reg ^ cmd_take;
        cnt_next    = cnt_reg + {1'b0, in_beat} - {1'b0, cmd_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat) q_reg[wr_ptr_reg] <= dec;
    end

endmodule

/* design/hmm_back.sv */
// Back end: MBC1 state, IO registers, internal and external RAM, result slot.
// Depends on hmm_pkg.
module hmm_back #(
    parameter int RAM_BANK_COUNT = hmm_pkg::RAM_BANK_COUNT_DEF,
    parameter int ROM_BANK_BITS  = hmm_pkg::ROM_BANK_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             mbc1_enable,
    input  logic             cmd_valid,
    input  hmm_pkg::cmd_t    cmd,
    output logic             cmd_take,
    output logic             clearing,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       read_data,
    output logic             rom_read,
    output logic [20:0]      rom_addr,
    output logic             serial_valid,
    output logic [7:0]       serial_byte,
    output logic             dma_request,
    output logic [7:0]       dma_page,
    output logic             timer_written
);
    import hmm_pkg::*;

    localparam int EXT_DEPTH = RAM_BANK_COUNT * 8192;
    localparam int EXT_AW    = $clog2(EXT_DEPTH);
    localparam logic [6:0] ROM_MASK = 7'((1 << ROM_BANK_BITS) - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [INT_AW-1:0] clr_idx_reg;
    logic              wait_ext_reg;
    logic [7:0]        buttons_reg, sb_reg, div_reg, ly_reg;
    logic [1:0]        joyp_reg;
    logic              gate_reg, mode_reg;
    logic [4:0]        bank_low_reg;
    logic [1:0]        bank_upper_reg;

    logic [7:0] int_mem [1 << INT_AW];
    logic [7:0] ext_mem [EXT_DEPTH];
    logic [7:0] int_q, ext_q;

    logic              out_valid_reg;
    logic [7:0]        rd_reg, sb_out_reg, dp_reg;
    logic              rr_reg, sv_reg, dr_reg, tw_reg;
    logic [20:0]       ra_reg;

    logic              out_free, start, mem_rd, load_direct, load_wait;
    logic [1:0]        ext_bank;
    logic [EXT_AW-1:0] ext_idx;
    logic [6:0]        rom_bank;
    logic [7:0]        joyp_byte, direct_rd, btn_mask;
    logic              int_we, ext_we;

    assign clearing = (state_reg == S_CLEAR);
    assign empty    = !out_valid_reg;
    assign out_free = !out_valid_reg || pop;
    assign start    = (state_reg == S_RUN) && cmd_valid && out_free;
    assign mem_rd   = (cmd.kind == K_INT_RD) || (cmd.kind == K_EXT_RD && gate_reg);
    assign cmd_take = start;
    assign load_direct = start && !mem_rd;
    assign load_wait   = (state_reg == S_WAIT) && out_free;

    // external RAM bank, reduced modulo the bank count
    always_comb
    begin
        ext_bank = mode_reg ? bank_upper_reg : 2'd0;
        if (RAM_BANK_COUNT == 3)
            ext_bank = (ext_bank == 2'd3) ? 2'd0 : ext_bank;
        else
            ext_bank = ext_bank & 2'(RAM_BANK_COUNT - 1);
    end
    assign ext_idx = EXT_AW'({ext_bank, cmd.addr[12:0]});

    // ROM bank for the fixed and the switchable window
    always_comb
    begin
        if (!cmd.addr[14])   rom_bank = 7'd0;
        else if (mbc1_enable) rom_bank = {bank_upper_reg, bank_low_reg};
        else                 rom_bank = 7'd1;
        rom_bank = rom_bank & ROM_MASK;
    end

    // joypad view and direct read data
    always_comb
    begin
        joyp_byte = {2'b00, joyp_reg, 4'h0};
        if (joyp_reg == 2'b10)      joyp_byte = {4'b0010, buttons_reg[3:0]};
        else if (joyp_reg == 2'b01) joyp_byte = {4'b0001, buttons_reg[7:4]};
        case (cmd.kind)
            K_EXT_RD:  direct_rd = 8'hFF;
            K_JOYP_RD: direct_rd = joyp_byte;
            K_SB_RD:   direct_rd = sb_reg;
            K_DIV_RD:  direct_rd = div_reg;
            K_LY_RD:   direct_rd = ly_reg;
            default:   direct_rd = 8'h00;
        endcase
    end

    assign btn_mask = 8'(1) << cmd.button_index;
    assign int_we   = start && (cmd.kind == K_INT_WR);
    assign ext_we   = start && (cmd.kind == K_EXT_WR) && gate_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_idx_reg == '1) state_next = S_RUN;
            S_RUN:   if (start && mem_rd) state_next = S_WAIT;
            S_WAIT:  if (out_free) state_next = S_RUN;
            default: state_next = S_CLEAR;
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            buttons_reg    <= 8'hFF;
            sb_reg         <= 8'h00;
            div_reg        <= 8'h00;
            ly_reg         <= 8'h00;
            joyp_reg       <= 2'b00;
            gate_reg       <= 1'b0;
            mode_reg       <= 1'b1;
            bank_low_reg   <= 5'd1;
            bank_upper_reg <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing) clr_idx_reg <= clr_idx_reg + 1'b1;
            if (start)
            begin
                case (cmd.kind)
                    K_MBC_WR:
                    begin
                        if (mbc1_enable)
                        begin
                            case (cmd.addr[14:13])
                                2'd0: gate_reg <= (cmd.data[3:0] == 4'hA);
                                2'd1: bank_low_reg <= (cmd.data[4:0] == 5'd0) ?
                                                      5'd1 : cmd.data[4:0];
                                2'd2: bank_upper_reg <= cmd.data[1:0];
                                default: mode_reg <= cmd.data[0];
                            endcase
                        end
                    end
                    K_JOYP_WR:  joyp_reg <= cmd.data[5:4];
                    K_SB_WR:    sb_reg <= cmd.data;
                    K_DIV_CLR:  div_reg <= 8'h00;
                    K_LY_CLR:   ly_reg <= 8'h00;
                    K_DIV_TICK: div_reg <= div_reg + 8'd1;
                    K_LY_TICK:  ly_reg <= ly_reg + 8'd1;
                    K_BUTTON:
                    begin
                        if (cmd.button_pressed) buttons_reg <= buttons_reg & ~btn_mask;
                        else                    buttons_reg <= buttons_reg | btn_mask;
                    end
                    default: ;
                endcase
            end
            if (load_direct || load_wait) out_valid_reg <= 1'b1;
            else if (pop)                 out_valid_reg <= 1'b0;
        end
    end

    // result slot payload
    always_ff @(posedge clk)
    begin
        if (start) wait_ext_reg <= (cmd.kind == K_EXT_RD);
        if (load_direct)
        begin
            rd_reg     <= direct_rd;
            rr_reg     <= (cmd.kind == K_ROM_RD);
            ra_reg     <= (cmd.kind == K_ROM_RD) ? {rom_bank, cmd.addr[13:0]} : 21'd0;
            sv_reg     <= cmd.sv;
            sb_out_reg <= (cmd.kind == K_SB_WR) ? cmd.data : sb_reg;
            dr_reg     <= cmd.dr;
            dp_reg     <= cmd.dr ? cmd.data : 8'h00;
            tw_reg     <= cmd.tw;
        end
        else if (load_wait)
        begin
            rd_reg     <= wait_ext_reg ? ext_q : int_q;
            rr_reg     <= 1'b0;
            ra_reg     <= 21'd0;
            sv_reg     <= 1'b0;
            sb_out_reg <= sb_reg;
            dr_reg     <= 1'b0;
            dp_reg     <= 8'h00;
            tw_reg     <= 1'b0;
        end
    end

    // internal store: clearing pass loads post-boot bytes
    always_ff @(posedge clk)
    begin
        if (clearing)    int_mem[clr_idx_reg] <= boot_byte(clr_idx_reg);
        else if (int_we) int_mem[cmd.idx] <= cmd.data;
        if (start && cmd.kind == K_INT_RD) int_q <= int_mem[cmd.idx];
    end

    // external banked RAM
    always_ff @(posedge clk)
    begin
        if (ext_we) ext_mem[ext_idx] <= cmd.data;
        if (start && cmd.kind == K_EXT_RD) ext_q <= ext_mem[ext_idx];
    end

    assign read_data     = rd_reg;
    assign rom_read      = rr_reg;
    assign rom_addr      = ra_reg;
    assign serial_valid  = sv_reg;
    assign serial_byte   = sb_out_reg;
    assign dma_request   = dr_reg;
    assign dma_page      = dp_reg;
    assign timer_written = tw_reg;

endmodule
